/* hw/rtl/pwp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwp_pkg
// Shared types and constants for the protobuf wire parser.
// ----------------------------------------------------------------------------
package pwp_pkg;

	localparam int LEN_BITS = 32;

	localparam logic [1:0] KIND_SCALAR  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	localparam logic [2:0] WT_VARINT  = 3'd0;
	localparam logic [2:0] WT_FIX64   = 3'd1;
	localparam logic [2:0] WT_LENGTH  = 3'd2;
	localparam logic [2:0] WT_FIX32   = 3'd5;

	localparam logic [3:0] VARINT_MAX_IDX = 4'd10;
	localparam logic [3:0] FIX64_BYTES    = 4'd8;
	localparam logic [3:0] FIX32_BYTES    = 4'd4;

	typedef enum logic [5:0] {
		PH_TAG     = 6'b000001,
		PH_VARINT  = 6'b000010,
		PH_FIX64   = 6'b000100,
		PH_LENGTH  = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_FIX32   = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [28:0] field_number;
		logic [2:0]  wire_type;
		logic [63:0] value;
		logic [7:0]  payload_byte;
		logic        last;
	} result_t;

endpackage
`default_nettype wire

/* hw/rtl/protobuf_wire_parser_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// protobuf_wire_parser_unit
// Protocol buffers wire format decoder, one message byte per word.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while byte_stall is low, into the input register.
// The decode logic sits between the input register and the result register,
// which takes the result as the byte leaves the input register. A byte gives
// at most one result: a scalar field, one payload byte, an empty payload mark
// or an error. The input stalls only while a finished result waits in the
// result register and a byte sits in the input register.
module protobuf_wire_parser_unit
	import pwp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_message,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic [1:0]       kind,
	output logic [28:0]      field_number,
	output logic [2:0]       wire_type,
	output logic [63:0]      value,
	output logic [7:0]       payload_byte,
	output logic             last
);

	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       eom_s1;
	logic       out_free;
	logic       advance;
	logic       res_valid;
	result_t    res;
	result_t    result_q;

	assign advance = valid_s1 && out_free;

	pwp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.data_byte     (data_byte),
		.end_of_message(end_of_message),
		.advance       (advance),
		.out_free      (out_free),
		.valid_s1      (valid_s1),
		.data_byte_s1  (data_byte_s1),
		.eom_s1        (eom_s1)
	);

	pwp_decode u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte_s1(data_byte_s1),
		.eom_s1      (eom_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	pwp_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.res_valid   (res_valid),
		.res         (res),
		.result_stall(result_stall),
		.out_free    (out_free),
		.result_valid(result_valid),
		.result_q    (result_q)
	);

	assign kind         = result_q.kind;
	assign field_number = result_q.field_number;
	assign wire_type    = result_q.wire_type;
	assign value        = result_q.value;
	assign payload_byte = result_q.payload_byte;
	assign last         = result_q.last;

endmodule
`default_nettype wire

/* hw/rtl/pwp_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwp_in_stage
// Input register for one message byte and its end-of-message flag.
// ----------------------------------------------------------------------------
module pwp_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       byte_valid,
	output logic            byte_stall,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_message,
	input  wire logic       advance,
	input  wire logic       out_free,
	output logic            valid_s1,
	output logic [7:0]      data_byte_s1,
	output logic            eom_s1
);

	logic load;

	assign byte_stall = valid_s1 && !out_free;
	assign load       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_byte_s1 <= data_byte;
			eom_s1       <= end_of_message;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/pwp_decode.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwp_decode
// Wire format state and per-byte decode of tags, varints, fixed values
// and length-delimited payloads.
// ----------------------------------------------------------------------------
module pwp_decode
	import pwp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte_s1,
	input  wire logic       eom_s1,
	output logic            res_valid,
	output result_t         res
);

	phase_t              phase_q, phase_n;
	logic [63:0]         acc_q, acc_n;
	logic [3:0]          idx_q, idx_n;
	logic [28:0]         hfn_q, hfn_n;
	logic [2:0]          hwt_q, hwt_n;
	logic [LEN_BITS-1:0] rem_q, rem_n;
	logic                skip_q, skip_n;

	logic [6:0]          sh7;
	logic [63:0]         vterm, acc_v, acc_f;
	logic [3:0]          idx_inc, idx_f, total;
	logic                vdone;
	logic [LEN_BITS-1:0] rem_dec;

	always_comb begin
		sh7     = 7'({idx_q, 3'b000}) - 7'(idx_q);
		vterm   = (idx_q < VARINT_MAX_IDX) ? (64'(data_byte_s1[6:0]) << sh7) : '0;
		acc_v   = acc_q | vterm;
		acc_f   = acc_q | (64'(data_byte_s1) << {idx_q[2:0], 3'b000});
		vdone   = !data_byte_s1[7];
		idx_inc = (idx_q < VARINT_MAX_IDX) ? idx_q + 4'd1 : idx_q;
		idx_f   = idx_q + 4'd1;
		total   = (phase_q == PH_FIX64) ? FIX64_BYTES : FIX32_BYTES;
		rem_dec = rem_q - LEN_BITS'(1);

		phase_n   = phase_q;
		acc_n     = acc_q;
		idx_n     = idx_q;
		hfn_n     = hfn_q;
		hwt_n     = hwt_q;
		rem_n     = rem_q;
		skip_n    = skip_q;
		res_valid = 1'b0;
		res       = '0;

		if (!skip_q) begin
			unique case (phase_q)
				PH_TAG: begin
					if (vdone) begin
						hfn_n = acc_v[31:3];
						hwt_n = acc_v[2:0];
						acc_n = '0;
						idx_n = '0;
						unique case (acc_v[2:0])
							WT_VARINT: phase_n = PH_VARINT;
							WT_FIX64:  phase_n = PH_FIX64;
							WT_LENGTH: phase_n = PH_LENGTH;
							WT_FIX32:  phase_n = PH_FIX32;
							default:   phase_n = PH_TAG;
						endcase
					end else begin
						acc_n = acc_v;
						idx_n = idx_inc;
					end
				end
				PH_VARINT: begin
					if (vdone) begin
						res_valid        = 1'b1;
						res.kind         = KIND_SCALAR;
						res.field_number = hfn_q;
						res.wire_type    = hwt_q;
						res.value        = acc_v;
						phase_n          = PH_TAG;
						acc_n            = '0;
						idx_n            = '0;
					end else begin
						acc_n = acc_v;
						idx_n = idx_inc;
					end
				end
				PH_FIX64, PH_FIX32: begin
					if (idx_f >= total) begin
						res_valid        = 1'b1;
						res.kind         = KIND_SCALAR;
						res.field_number = hfn_q;
						res.wire_type    = hwt_q;
						res.value        = acc_f;
						phase_n          = PH_TAG;
						acc_n            = '0;
						idx_n            = '0;
					end else begin
						acc_n = acc_f;
						idx_n = idx_f;
					end
				end
				PH_LENGTH: begin
					if (vdone) begin
						acc_n = '0;
						idx_n = '0;
						if ((acc_v >> LEN_BITS) != 64'd0) begin
							res_valid        = 1'b1;
							res.kind         = KIND_ERROR;
							res.field_number = hfn_q;
							res.wire_type    = hwt_q;
							skip_n           = 1'b1;
							phase_n          = PH_TAG;
						end else if (acc_v == 64'd0) begin
							res_valid        = 1'b1;
							res.kind         = KIND_EMPTY;
							res.field_number = hfn_q;
							res.wire_type    = hwt_q;
							phase_n          = PH_TAG;
						end else begin
							rem_n   = acc_v[LEN_BITS-1:0];
							phase_n = PH_PAYLOAD;
						end
					end else begin
						acc_n = acc_v;
						idx_n = idx_inc;
					end
				end
				PH_PAYLOAD: begin
					res_valid        = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.field_number = hfn_q;
					res.wire_type    = hwt_q;
					res.payload_byte = data_byte_s1;
					res.last         = (rem_dec == '0);
					rem_n            = rem_dec;
					if (rem_dec == '0) begin
						phase_n = PH_TAG;
					end
				end
				default: begin
					phase_n = PH_TAG;
					acc_n   = '0;
					idx_n   = '0;
				end
			endcase
		end

		if (eom_s1) begin
			if (!skip_n && (phase_n != PH_TAG || idx_n != 4'd0)) begin
				res_valid        = 1'b1;
				res              = '0;
				res.kind         = KIND_ERROR;
				res.field_number = (phase_n == PH_TAG) ? 29'd0 : hfn_n;
				res.wire_type    = (phase_n == PH_TAG) ? 3'd0 : hwt_n;
			end
			phase_n = PH_TAG;
			acc_n   = '0;
			idx_n   = '0;
			hfn_n   = '0;
			hwt_n   = '0;
			rem_n   = '0;
			skip_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			idx_q   <= '0;
			hfn_q   <= '0;
			hwt_q   <= '0;
			rem_q   <= '0;
			skip_q  <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			acc_q   <= acc_n;
			idx_q   <= idx_n;
			hfn_q   <= hfn_n;
			hwt_q   <= hwt_n;
			rem_q   <= rem_n;
			skip_q  <= skip_n;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/pwp_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pwp_out_reg
// Result register that holds a decoded word until it is taken.
// ----------------------------------------------------------------------------
module pwp_out_reg
	import pwp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    advance,
	input  wire logic    res_valid,
	input  wire result_t res,
	input  wire logic    result_stall,
	output logic         out_free,
	output logic         result_valid,
	output result_t      result_q
);

	assign out_free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_free) begin
			result_valid <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && res_valid) begin
			result_q <= res;
		end
	end

endmodule
`default_nettype wire
